/* rtl/pqcd_pkg.sv */
// ----------------------------------------------------------------------------
// pqcd_pkg
// Shared types and constants of the four-channel probabilistic clock divider.
// ----------------------------------------------------------------------------
package pqcd_pkg;

    localparam int CH_N             = 4;
    localparam int CNT_W            = 6;
    localparam int THR_W            = 17;
    localparam int RND_W            = 16;
    localparam int IDX_W            = 3;
    localparam int CFG_W            = THR_W;
    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    localparam int PULSE_TICKS_DEF  = 48;
    localparam int MAX_DIVISOR_DEF  = 32;

    localparam logic [THR_W-1:0] THR_RESET = 17'h10000;
    localparam logic [CNT_W-1:0] DIV_RESET = 6'd1;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_DIV_CH1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_DIV_CH2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIV_CH3 = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIV_CH4 = 3'd3;
    localparam logic [IDX_W-1:0] REG_CHANCE  = 3'd4;

    typedef struct packed {
        logic             clock_level;
        logic [RND_W-1:0] random_value;
        logic [CH_N-1:0]  toggle_bits;
        logic             all_on_request;
        logic             all_off_request;
    } in_word_t;

    typedef struct packed {
        logic [CH_N-1:0] channel_pulses;
        logic            or_pulse;
        logic            xor_pulse;
        logic [CH_N-1:0] channel_enables;
        logic [CH_N-1:0] count_zero_marks;
    } out_word_t;

    typedef struct packed {
        logic [CH_N-1:0][CNT_W-1:0] divisor;
        logic [THR_W-1:0]           threshold;
    } cfg_t;

endpackage

/* rtl/probabilistic_quad_clock_divider.sv */
// ----------------------------------------------------------------------------
// probabilistic_quad_clock_divider
// Four-channel clock divider with a random pulse gate and global on/off.
// ----------------------------------------------------------------------------
// Path: input register, then one update pass into the two-entry result
//   buffer.
// Throughput: one word per cycle while the result buffer has space.
// Reset: synchronous active-low aresetn clears counters, timers and buffers,
//   sets all enables, divisors to 1 and the threshold to always.
module probabilistic_quad_clock_divider #(
    parameter int PULSE_TICKS = pqcd_pkg::PULSE_TICKS_DEF,
    parameter int MAX_DIVISOR = pqcd_pkg::MAX_DIVISOR_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  pqcd_pkg::in_word_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output pqcd_pkg::out_word_t        m_data,
    input  logic                       cfg_we,
    input  logic [pqcd_pkg::IDX_W-1:0] cfg_index,
    input  logic [pqcd_pkg::CFG_W-1:0] cfg_wdata
);
    import pqcd_pkg::*;

    cfg_t      cfg;
    in_word_t  in_data_reg;
    logic      in_valid_reg;
    logic      advance;
    logic      space;
    out_word_t core_word;

    assign advance = in_valid_reg & space;
    assign s_ready = ~in_valid_reg | advance;

    // Hold the input word until the core takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg <= s_data;
    end

    pqcd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pqcd_core #(
        .PULSE_TICKS (PULSE_TICKS),
        .MAX_DIVISOR (MAX_DIVISOR)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_word  (in_data_reg),
        .cfg      (cfg),
        .out_word (core_word)
    );

    pqcd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (advance),
        .push_word (core_word),
        .space     (space),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

/* rtl/pqcd_cfg.sv */
// ----------------------------------------------------------------------------
// pqcd_cfg
// Configuration register file: four divisors and the chance threshold.
// ----------------------------------------------------------------------------
module pqcd_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [pqcd_pkg::IDX_W-1:0] cfg_index,
    input  logic [pqcd_pkg::CFG_W-1:0] cfg_wdata,
    output pqcd_pkg::cfg_t             cfg
);
    import pqcd_pkg::*;

    cfg_t cfg_reg;

    // Write the addressed register, ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.divisor   <= {CH_N{DIV_RESET}};
            cfg_reg.threshold <= THR_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DIV_CH1: cfg_reg.divisor[0] <= cfg_wdata[CNT_W-1:0];
                REG_DIV_CH2: cfg_reg.divisor[1] <= cfg_wdata[CNT_W-1:0];
                REG_DIV_CH3: cfg_reg.divisor[2] <= cfg_wdata[CNT_W-1:0];
                REG_DIV_CH4: cfg_reg.divisor[3] <= cfg_wdata[CNT_W-1:0];
                REG_CHANCE:  cfg_reg.threshold  <= cfg_wdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/pqcd_core.sv */
// ----------------------------------------------------------------------------
// pqcd_core
// Divider state and the per-tick update: counters, enables, pulse timers.
// ----------------------------------------------------------------------------
module pqcd_core #(
    parameter int PULSE_TICKS = pqcd_pkg::PULSE_TICKS_DEF,
    parameter int MAX_DIVISOR = pqcd_pkg::MAX_DIVISOR_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  pqcd_pkg::in_word_t  in_word,
    input  pqcd_pkg::cfg_t      cfg,
    output pqcd_pkg::out_word_t out_word
);
    import pqcd_pkg::*;

    localparam int TIMER_W = $clog2(PULSE_TICKS + 1);
    localparam logic [TIMER_W-1:0] PT  = TIMER_W'(PULSE_TICKS);
    localparam logic [CNT_W-1:0]   MAXD = CNT_W'(MAX_DIVISOR);

    logic [CH_N-1:0][CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CH_N-1:0][TIMER_W-1:0] timer_reg, timer_next;
    logic [CH_N-1:0]              en_reg, en_next;
    logic [CH_N-1:0]              prev_tog_reg;
    logic                         chance_reg, chance_next;
    logic                         prev_clk_reg;

    logic                         clk_rise;
    logic [CH_N-1:0][CNT_W-1:0]   cnt_inc;
    logic [CH_N-1:0][CNT_W-1:0]   eff_div;
    logic [CH_N-1:0][TIMER_W-1:0] timer_set;
    logic [CH_N-1:0]              pulses;
    logic [CH_N-1:0]              zero_marks;
    logic [CH_N-1:0]              en_forced;

    // Update all state for one tick
    always_comb begin
        clk_rise    = in_word.clock_level & ~prev_clk_reg;
        chance_next = clk_rise ? ({1'b0, in_word.random_value} < cfg.threshold)
                               : chance_reg;

        // off wins over on, then rising toggles flip
        en_forced = en_reg;
        if (in_word.all_on_request)  en_forced = '1;
        if (in_word.all_off_request) en_forced = '0;
        en_next = en_forced ^ (in_word.toggle_bits & ~prev_tog_reg);

        for (int i = 0; i < CH_N; i++) begin
            cnt_inc[i] = (clk_rise && cnt_reg[i] != CNT_SAT)
                       ? cnt_reg[i] + CNT_W'(1) : cnt_reg[i];
            zero_marks[i] = (cnt_inc[i] == '0);

            // clamp divisor into 1..MAX_DIVISOR
            if (cfg.divisor[i] == '0)      eff_div[i] = CNT_W'(1);
            else if (cfg.divisor[i] > MAXD) eff_div[i] = MAXD;
            else                           eff_div[i] = cfg.divisor[i];

            timer_set[i] = timer_reg[i];
            cnt_next[i]  = cnt_inc[i];
            if (en_next[i]) begin
                if (cnt_inc[i] == eff_div[i] && chance_next && timer_reg[i] < PT)
                    timer_set[i] = PT;
                if (cnt_inc[i] >= eff_div[i])
                    cnt_next[i] = '0;
            end

            pulses[i]     = (timer_set[i] != '0);
            timer_next[i] = pulses[i] ? timer_set[i] - TIMER_W'(1) : timer_set[i];
        end
    end

    // Hold state between accepted words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            timer_reg    <= '0;
            en_reg       <= '1;
            prev_tog_reg <= '0;
            chance_reg   <= 1'b0;
            prev_clk_reg <= 1'b0;
        end else if (advance) begin
            cnt_reg      <= cnt_next;
            timer_reg    <= timer_next;
            en_reg       <= en_next;
            prev_tog_reg <= in_word.toggle_bits;
            chance_reg   <= chance_next;
            prev_clk_reg <= in_word.clock_level;
        end
    end

    // Assemble the result word
    always_comb begin
        out_word.channel_pulses   = pulses;
        out_word.or_pulse         = |pulses;
        out_word.xor_pulse        = ^pulses;
        out_word.channel_enables  = en_next;
        out_word.count_zero_marks = zero_marks;
    end

endmodule

/* rtl/pqcd_out_buf.sv */
// ----------------------------------------------------------------------------
// pqcd_out_buf
// Two-entry result buffer so a new word enters while one waits downstream.
// ----------------------------------------------------------------------------
module pqcd_out_buf (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  pqcd_pkg::out_word_t push_word,
    output logic                space,
    output logic                m_valid,
    input  logic                m_ready,
    output pqcd_pkg::out_word_t m_data
);
    import pqcd_pkg::*;

    out_word_t   head_reg, tail_reg;
    logic [1:0]  count_reg;
    logic        pop;

    assign pop     = m_valid & m_ready;
    assign space   = (count_reg != 2'd2);
    assign m_valid = (count_reg != 2'd0);
    assign m_data  = head_reg;

    // Track the fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: ;
            endcase
        end
    end

    // Shift words toward the head
    always_ff @(posedge aclk) begin
        unique case ({push, pop})
            2'b11: begin
                if (count_reg == 2'd2) begin
                    head_reg <= tail_reg;
                    tail_reg <= push_word;
                end else begin
                    head_reg <= push_word;
                end
            end
            2'b10: begin
                if (count_reg == 2'd0) head_reg <= push_word;
                else                   tail_reg <= push_word;
            end
            2'b01:   head_reg <= tail_reg;
            default: ;
        endcase
    end

endmodule
